### hw/rtl/sorted_multiset_store_defines.svh
// Assertion macros shared by the sorted_multiset_store checkers.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SORTED_MULTISET_STORE_DEFINES_SVH
`define SORTED_MULTISET_STORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sms_pkg.sv
// Package for sorted_multiset_store: command and status codes, cell ops,
// and the control/status structs between top level and cell chain.
package sms_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [2:0] STS_ADDED        = 3'd0;
  localparam logic [2:0] STS_FULL         = 3'd1;
  localparam logic [2:0] STS_REMOVED      = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND    = 3'd3;
  localparam logic [2:0] STS_EMPTY_REMOVE = 3'd4;
  localparam logic [2:0] STS_ELEMENT      = 3'd5;
  localparam logic [2:0] STS_CLEARED      = 3'd6;
  localparam logic [2:0] STS_EMPTY_READ   = 3'd7;

  typedef enum logic [2:0] {
    C_HOLD,
    C_CMP,
    C_INS,
    C_DEL,
    C_ROT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_READ
  } state_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] operand;
  } chain_ctl_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] head;
  } chain_sts_t;

endpackage

### hw/rtl/sms_cell.sv
// One storage cell of the sorted chain: an entry plus its compare flags.
// Depends on sms_pkg.
module sms_cell (
  input  logic               clk,
  input  sms_pkg::cell_op_t  op,
  input  logic signed [31:0] operand,
  input  logic               valid,
  input  logic               prev_lt,
  input  logic               tail,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  input  logic signed [31:0] head_entry,
  output logic signed [31:0] entry,
  output logic               lt,
  output logic               eq
);
  import sms_pkg::*;

  logic signed [31:0] entry_r, entry_nxt;
  logic               lt_r, lt_nxt;
  logic               eq_r, eq_nxt;
  logic               ge_r, ge_nxt;

  always_comb begin
    entry_nxt = entry_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    ge_nxt    = ge_r;
    case (op)
      C_CMP: begin
        lt_nxt = valid && (entry_r < operand);
        eq_nxt = valid && (entry_r == operand);
        ge_nxt = valid && !(entry_r < operand);
      end
      C_INS: begin
        // cells below the insert point keep; the insert point takes the operand
        if (!lt_r) begin
          entry_nxt = prev_lt ? operand : left_entry;
        end
      end
      C_DEL: begin
        if (ge_r) begin
          entry_nxt = right_entry;
        end
      end
      C_ROT: begin
        entry_nxt = tail ? head_entry : right_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
    ge_r    <= ge_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

### hw/rtl/sms_chain.sv
// Row of sms_cell instances wired to their neighbors, plus the match flag.
// Depends on sms_pkg and sms_cell.
module sms_chain #(
  parameter int CAPACITY = 32
) (
  input  logic                             clk,
  input  sms_pkg::chain_ctl_t              ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]    count,
  output sms_pkg::chain_sts_t              sts
);
  import sms_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] entry [CAPACITY];
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               prev_lt;
    logic signed [31:0] left_e;
    logic signed [31:0] right_e;

    if (i == 0) begin : g_first
      assign prev_lt = 1'b1;
      assign left_e  = entry[0];
    end else begin : g_mid
      assign prev_lt = lt_v[i-1];
      assign left_e  = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry[i];
    end else begin : g_nlast
      assign right_e = entry[i+1];
    end

    sms_cell u_cell (
      .clk         (clk),
      .op          (ctl.op),
      .operand     (ctl.operand),
      .valid       (CW'(i) < count),
      .prev_lt     (prev_lt),
      .tail        (CW'(i + 1) == count),
      .left_entry  (left_e),
      .right_entry (right_e),
      .head_entry  (entry[0]),
      .entry       (entry[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  assign sts.found = |eq_v;
  assign sts.head  = entry[0];

endmodule

### hw/rtl/sorted_multiset_store.sv
// sorted_multiset_store: add/remove/clear compare in the accept cycle and then
// apply, using the compare flags registered in every cell before the shift.
// Readout of N entries streams one entry per cycle by rotating the cell chain,
// as long as the output is not stalled.
// Synchronous active-low reset empties the store (count zero); entry contents
// are not cleared and never read while invalid.
module sorted_multiset_store #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_item_value,
  output logic [5:0]         out_entry_count,
  output logic               out_last
);
  import sms_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     rd_r, rd_nxt;
  logic              out_valid_r;

  // latched transaction
  cmd_t               cmd_r;
  logic signed [31:0] op_r;

  // output register (payload, no reset)
  logic [2:0]         sts_r, sts_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               load_out;

  chain_ctl_t ctl;
  chain_sts_t csts;

  logic          slot_free;
  logic          accept;
  logic          full;
  logic          empty;
  logic          rd_last;
  logic [CW+5:0] cnt_wide_new;
  logic [CW+5:0] cnt_wide_old;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign rd_last   = (CW'(CW'(rd_r) + CW'(1)) == count_r);

  // widened views of the count; their low 6 bits wrap when CAPACITY reaches 64
  assign cnt_wide_new = {6'd0, count_nxt};
  assign cnt_wide_old = {6'd0, count_r};

  sms_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .sts   (csts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (cmd_r == CMD_READ && !empty) begin
          state_nxt = S_READ;
        end else if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (slot_free && rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain control, count update and result formation
  always_comb begin
    ctl.op      = C_HOLD;
    ctl.operand = op_r;
    count_nxt   = count_r;
    rd_nxt      = rd_r;
    load_out    = 1'b0;
    sts_nxt     = sts_r;
    val_nxt     = op_r;
    cnt_nxt     = cnt_r;
    last_nxt    = 1'b1;
    case (state_r)
      S_IDLE: begin
        // compare against the incoming operand in the accept cycle
        if (accept) begin
          ctl.op      = C_CMP;
          ctl.operand = in_operand_value;
        end
      end
      S_APPLY: begin
        if (slot_free && !(cmd_r == CMD_READ && !empty)) begin
          load_out = 1'b1;
          case (cmd_r)
            CMD_ADD: begin
              if (full) begin
                sts_nxt = STS_FULL;
              end else begin
                ctl.op    = C_INS;
                count_nxt = count_r + 1'b1;
                sts_nxt   = STS_ADDED;
              end
              cnt_nxt = cnt_wide_new[5:0];
            end
            CMD_REMOVE: begin
              if (empty) begin
                sts_nxt = STS_EMPTY_REMOVE;
              end else if (!csts.found) begin
                sts_nxt = STS_NOT_FOUND;
              end else begin
                ctl.op    = C_DEL;
                count_nxt = count_r - 1'b1;
                sts_nxt   = STS_REMOVED;
              end
              cnt_nxt = cnt_wide_new[5:0];
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              sts_nxt   = STS_CLEARED;
              cnt_nxt   = cnt_wide_old[5:0];
            end
            default: begin
              // readout of an empty store
              sts_nxt = STS_EMPTY_READ;
              cnt_nxt = cnt_wide_old[5:0];
            end
          endcase
        end
      end
      S_READ: begin
        // emit the head, rotate the chain by one
        if (slot_free) begin
          load_out = 1'b1;
          ctl.op   = C_ROT;
          sts_nxt  = STS_ELEMENT;
          val_nxt  = csts.head;
          cnt_nxt  = cnt_wide_old[5:0];
          last_nxt = rd_last;
          rd_nxt   = rd_last ? '0 : rd_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_command);
      op_r  <= in_operand_value;
    end
    if (load_out) begin
      sts_r  <= sts_nxt;
      val_r  <= val_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = sts_r;
  assign out_item_value  = val_r;
  assign out_entry_count = cnt_r;
  assign out_last        = last_r;

endmodule

### hw/rtl/sms_checker.sv
// Port-level checker for sorted_multiset_store, bound to the top level.
// Depends on sms_pkg and sorted_multiset_store_defines.svh.
`include "sorted_multiset_store_defines.svh"

module sms_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic signed [31:0] in_operand_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_item_value,
  input logic [5:0]         out_entry_count,
  input logic               out_last
);
  import sms_pkg::*;

  // a stalled result stays valid and keeps its item value
  `SMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item_value), "result dropped or changed while stalled")

  // only readout elements may be non-final
  `SMS_ASSERT_NOW(a_single_last, out_valid && out_status != STS_ELEMENT, out_last, "non-element result without last")

  // a readout stream continues without gaps once the output is taken
  `SMS_ASSERT_NEXT(a_stream_cont, out_valid && out_ready && !out_last, out_valid && out_status == STS_ELEMENT, "readout stream broken")

  // no new command accepted in the middle of a readout
  `SMS_ASSERT_NOW(a_no_accept_mid, out_valid && !out_last, !in_ready, "input ready during readout")

endmodule

bind sorted_multiset_store sms_checker u_sms_checker (.*);
